### src/tlc_pkg.sv
package tlc_pkg;

    localparam int TABLE_LENGTH     = 20;
    localparam int SAMPLES_AVERAGED = 3;
    localparam int ROM_ENTRIES      = 20;
    localparam int TBL_N = (TABLE_LENGTH < ROM_ENTRIES) ? TABLE_LENGTH : ROM_ENTRIES;

    localparam int ROM_IDX_W = $clog2(ROM_ENTRIES);
    localparam int IDX_W     = (TBL_N > 1) ? $clog2(TBL_N) : 1;

    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 14;
    localparam int AVG_W    = SUM_W;
    localparam int RAW_W    = 11;
    localparam int TMP_W    = 11;
    localparam int TEMP_W   = 13;
    localparam int COUNT_W  = $clog2(SAMPLES_AVERAGED + 1);

    // average = (sum * ceil(2^K / N)) >> K, exact for sums below 2^SUM_W
    localparam int AVG_K   = SUM_W + 2;
    localparam int RECIP_W = AVG_K + 1;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'((2 ** AVG_K + SAMPLES_AVERAGED - 1) / SAMPLES_AVERAGED);

    localparam int DIV_W     = RAW_W + TMP_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam int SCALE_W     = 9;
    localparam logic [SCALE_W-1:0] SCALE_MUL = 9'd500;
    localparam int SCALE_SHIFT = 10;

    localparam logic [SAMPLE_W-1:0] DISCONNECT_CODE = 12'd1023;

    typedef logic [1:0] t_sensor;
    localparam t_sensor SENSOR_THERM  = 2'd0;
    localparam t_sensor SENSOR_SCALED = 2'd1;
    localparam t_sensor SENSOR_DIRECT = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                read_fault;
    } t_in_item;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     fault_seen;
        logic                     disconnected;
        logic                     invalid_type;
    } t_out_item;

    // microcode
    localparam int PC_W   = 4;
    localparam int OP_W   = 4;
    localparam int COND_W = 4;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [COND_W-1:0] t_cond;

    localparam t_op OP_NOP       = 4'd0;
    localparam t_op OP_ACCEPT    = 4'd1;
    localparam t_op OP_AVG       = 4'd2;
    localparam t_op OP_SEARCH    = 4'd3;
    localparam t_op OP_PRODUCT   = 4'd4;
    localparam t_op OP_DIV_LOAD  = 4'd5;
    localparam t_op OP_DIV_STEP  = 4'd6;
    localparam t_op OP_INTERP    = 4'd7;
    localparam t_op OP_TEMP_LAST = 4'd8;
    localparam t_op OP_DIRECT    = 4'd9;
    localparam t_op OP_EMIT      = 4'd10;

    localparam t_cond C_NEXT        = 4'd0;
    localparam t_cond C_ALWAYS      = 4'd1;
    localparam t_cond C_NO_REQ      = 4'd2;
    localparam t_cond C_NOT_THERM   = 4'd3;
    localparam t_cond C_NOT_FULL    = 4'd4;
    localparam t_cond C_SEARCH_MORE = 4'd5;
    localparam t_cond C_MISS        = 4'd6;
    localparam t_cond C_DIV_MORE    = 4'd7;
    localparam t_cond C_OUT_BUSY    = 4'd8;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic not_therm;
        logic not_full;
        logic search_more;
        logic miss;
        logic div_more;
        logic out_busy;
    } t_status;

    function automatic logic [RAW_W-1:0] rom_raw(input logic [ROM_IDX_W-1:0] idx);
        logic [RAW_W-1:0] v;
        case (idx)
            5'd0:    v = 11'd1;
            5'd1:    v = 11'd54;
            5'd2:    v = 11'd107;
            5'd3:    v = 11'd160;
            5'd4:    v = 11'd213;
            5'd5:    v = 11'd266;
            5'd6:    v = 11'd319;
            5'd7:    v = 11'd372;
            5'd8:    v = 11'd425;
            5'd9:    v = 11'd478;
            5'd10:   v = 11'd531;
            5'd11:   v = 11'd584;
            5'd12:   v = 11'd637;
            5'd13:   v = 11'd690;
            5'd14:   v = 11'd743;
            5'd15:   v = 11'd796;
            5'd16:   v = 11'd849;
            5'd17:   v = 11'd902;
            5'd18:   v = 11'd955;
            5'd19:   v = 11'd1008;
            default: v = 11'd1008;
        endcase
        return v;
    endfunction

    function automatic logic signed [TMP_W-1:0] rom_temp(input logic [ROM_IDX_W-1:0] idx);
        logic signed [TMP_W-1:0] v;
        case (idx)
            5'd0:    v = 11'sd599;
            5'd1:    v = 11'sd160;
            5'd2:    v = 11'sd123;
            5'd3:    v = 11'sd103;
            5'd4:    v = 11'sd90;
            5'd5:    v = 11'sd79;
            5'd6:    v = 11'sd70;
            5'd7:    v = 11'sd62;
            5'd8:    v = 11'sd55;
            5'd9:    v = 11'sd49;
            5'd10:   v = 11'sd43;
            5'd11:   v = 11'sd37;
            5'd12:   v = 11'sd31;
            5'd13:   v = 11'sd25;
            5'd14:   v = 11'sd19;
            5'd15:   v = 11'sd12;
            5'd16:   v = 11'sd5;
            5'd17:   v = -11'sd3;
            5'd18:   v = -11'sd16;
            5'd19:   v = -11'sd42;
            default: v = -11'sd42;
        endcase
        return v;
    endfunction

endpackage

### src/tlc_useq.sv
module tlc_useq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  tlc_pkg::t_status i_status,
    output tlc_pkg::t_uword  o_uword
);
    import tlc_pkg::*;

    localparam logic [PC_W-1:0] L_IDLE       = 4'd0;
    localparam logic [PC_W-1:0] L_CHECK_TYPE = 4'd1;
    localparam logic [PC_W-1:0] L_CHECK_FULL = 4'd2;
    localparam logic [PC_W-1:0] L_AVG        = 4'd3;
    localparam logic [PC_W-1:0] L_SEARCH     = 4'd4;
    localparam logic [PC_W-1:0] L_MISS_CHECK = 4'd5;
    localparam logic [PC_W-1:0] L_PRODUCT    = 4'd6;
    localparam logic [PC_W-1:0] L_DIV_LOAD   = 4'd7;
    localparam logic [PC_W-1:0] L_DIV_STEP   = 4'd8;
    localparam logic [PC_W-1:0] L_INTERP     = 4'd9;
    localparam logic [PC_W-1:0] L_TEMP_LAST  = 4'd10;
    localparam logic [PC_W-1:0] L_DIRECT     = 4'd11;
    localparam logic [PC_W-1:0] L_EMIT       = 4'd12;
    localparam logic [PC_W-1:0] L_DONE       = 4'd13;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            L_IDLE:       w = '{OP_ACCEPT,    C_NO_REQ,      L_IDLE};
            L_CHECK_TYPE: w = '{OP_NOP,       C_NOT_THERM,   L_DIRECT};
            L_CHECK_FULL: w = '{OP_NOP,       C_NOT_FULL,    L_IDLE};
            L_AVG:        w = '{OP_AVG,       C_NEXT,        L_IDLE};
            L_SEARCH:     w = '{OP_SEARCH,    C_SEARCH_MORE, L_SEARCH};
            L_MISS_CHECK: w = '{OP_NOP,       C_MISS,        L_TEMP_LAST};
            L_PRODUCT:    w = '{OP_PRODUCT,   C_NEXT,        L_IDLE};
            L_DIV_LOAD:   w = '{OP_DIV_LOAD,  C_NEXT,        L_IDLE};
            L_DIV_STEP:   w = '{OP_DIV_STEP,  C_DIV_MORE,    L_DIV_STEP};
            L_INTERP:     w = '{OP_INTERP,    C_ALWAYS,      L_EMIT};
            L_TEMP_LAST:  w = '{OP_TEMP_LAST, C_ALWAYS,      L_EMIT};
            L_DIRECT:     w = '{OP_DIRECT,    C_NEXT,        L_IDLE};
            L_EMIT:       w = '{OP_EMIT,      C_OUT_BUSY,    L_EMIT};
            L_DONE:       w = '{OP_NOP,       C_ALWAYS,      L_IDLE};
            default:      w = '{OP_NOP,       C_ALWAYS,      L_IDLE};
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          w_uword;
    logic            w_jump;

    always_comb begin
        w_uword = ucode(r_pc);
        unique case (w_uword.cond)
            C_NEXT:        w_jump = 1'b0;
            C_ALWAYS:      w_jump = 1'b1;
            C_NO_REQ:      w_jump = !i_in_valid;
            C_NOT_THERM:   w_jump = i_status.not_therm;
            C_NOT_FULL:    w_jump = i_status.not_full;
            C_SEARCH_MORE: w_jump = i_status.search_more;
            C_MISS:        w_jump = i_status.miss;
            C_DIV_MORE:    w_jump = i_status.div_more;
            C_OUT_BUSY:    w_jump = i_status.out_busy;
            default:       w_jump = 1'b1;
        endcase
        n_pc = w_jump ? w_uword.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= L_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = w_uword;

endmodule

### src/tlc_div.sv
module tlc_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic                      i_step,
    input  logic [tlc_pkg::DIV_W-1:0] i_dividend,
    input  logic [tlc_pkg::RAW_W-1:0] i_divisor,
    output logic [tlc_pkg::DIV_W-1:0] o_quotient,
    output logic                      o_more
);
    import tlc_pkg::*;

    logic [DIV_W-1:0]     r_quo;
    logic [RAW_W-1:0]     r_rem;
    logic [RAW_W-1:0]     r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [RAW_W:0]       w_shift;
    logic [RAW_W:0]       w_sub;
    logic                 w_ge;

    // restoring division, one quotient bit per cycle while i_step is high
    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_sub   = w_shift - {1'b0, r_dvs};
    assign w_ge    = w_shift >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= DIV_CNT_W'(DIV_W);
        end else if (i_step && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (i_step && r_cnt != '0) begin
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_sub[RAW_W-1:0] : w_shift[RAW_W-1:0];
        end
    end

    assign o_quotient = r_quo;
    assign o_more     = r_cnt > DIV_CNT_W'(1);

endmodule

### src/tlc_dpath.sv
module tlc_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tlc_pkg::t_uword    i_uword,
    input  logic               i_cfg_valid,
    input  tlc_pkg::t_sensor   i_cfg_data,
    input  logic               i_in_valid,
    input  tlc_pkg::t_in_item  i_in_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output tlc_pkg::t_out_item o_out_data,
    output tlc_pkg::t_status   o_status
);
    import tlc_pkg::*;

    t_sensor                   r_sensor_type;
    logic [SUM_W-1:0]          r_sum;
    logic [COUNT_W-1:0]        r_count;
    logic                      r_acc_fault;
    logic                      r_acc_disc;
    logic                      r_out_valid;
    t_out_item                 r_out;

    logic [SAMPLE_W-1:0]       r_sample;
    logic                      r_smp_fault;
    logic                      r_smp_disc;
    logic [AVG_W-1:0]          r_avg;
    logic [IDX_W-1:0]          r_idx;
    logic                      r_neg;
    logic [DIV_W-1:0]          r_prod_mag;
    logic [RAW_W-1:0]          r_den;
    logic signed [TMP_W-1:0]   r_t0;
    logic signed [TEMP_W-1:0]  r_temp;
    logic                      r_res_fault;
    logic                      r_res_disc;
    logic                      r_res_inv;

    logic                      w_accept;
    logic                      w_in_disc;
    logic                      w_out_busy;
    logic [IDX_W-1:0]          w_idx_prev;
    logic [RAW_W-1:0]          w_r0;
    logic [RAW_W-1:0]          w_r1;
    logic signed [TMP_W-1:0]   w_t0;
    logic signed [TMP_W-1:0]   w_t1;
    logic                      w_hit;
    logic signed [RAW_W:0]     w_diff;
    logic signed [TMP_W:0]     w_dt;
    logic signed [RAW_W+TMP_W+1:0] w_prod;
    logic [RAW_W+TMP_W+1:0]    w_prod_abs;
    logic [SUM_W+RECIP_W-1:0]  w_avg_prod;
    logic [SAMPLE_W+SCALE_W-1:0] w_scaled;
    logic [DIV_W-1:0]          w_quo;
    logic                      w_div_more;
    logic signed [DIV_W+1:0]   w_qs;
    logic signed [DIV_W+1:0]   w_interp;
    logic signed [TEMP_W-1:0]  w_t0_ext;
    logic signed [TEMP_W-1:0]  w_t1_ext;

    assign w_accept   = (i_uword.op == OP_ACCEPT) && i_in_valid;
    assign w_in_disc  = i_in_data.sample == DISCONNECT_CODE;
    assign w_out_busy = r_out_valid && !i_out_ready;

    assign w_idx_prev = r_idx - 1'b1;
    assign w_r1 = rom_raw(ROM_IDX_W'(r_idx));
    assign w_t1 = rom_temp(ROM_IDX_W'(r_idx));
    assign w_r0 = rom_raw(ROM_IDX_W'(w_idx_prev));
    assign w_t0 = rom_temp(ROM_IDX_W'(w_idx_prev));
    assign w_hit = AVG_W'(w_r1) > r_avg;

    // on a hit the average is below the entry, so it fits RAW_W bits
    assign w_diff = $signed({1'b0, r_avg[RAW_W-1:0]}) - $signed({1'b0, w_r0});
    assign w_dt   = $signed({w_t1[TMP_W-1], w_t1}) - $signed({w_t0[TMP_W-1], w_t0});
    assign w_prod = w_diff * w_dt;
    assign w_prod_abs = w_prod[RAW_W+TMP_W+1] ? -w_prod : w_prod;

    assign w_avg_prod = r_sum * AVG_RECIP;
    assign w_scaled   = r_sample * SCALE_MUL;

    assign w_qs     = $signed({2'b00, w_quo});
    assign w_interp = $signed({{(DIV_W+2-TMP_W){r_t0[TMP_W-1]}}, r_t0})
                      + (r_neg ? -w_qs : w_qs);
    assign w_t0_ext = {{(TEMP_W-TMP_W){r_t0[TMP_W-1]}}, r_t0};
    assign w_t1_ext = {{(TEMP_W-TMP_W){w_t1[TMP_W-1]}}, w_t1};

    tlc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (i_uword.op == OP_DIV_LOAD),
        .i_step     (i_uword.op == OP_DIV_STEP),
        .i_dividend (r_prod_mag),
        .i_divisor  (r_den),
        .o_quotient (w_quo),
        .o_more     (w_div_more)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_type <= SENSOR_THERM;
            r_sum         <= '0;
            r_count       <= '0;
            r_acc_fault   <= 1'b0;
            r_acc_disc    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_sensor_type <= i_cfg_data;
            end
            if (w_accept) begin
                if (r_sensor_type == SENSOR_THERM) begin
                    r_sum       <= r_sum + SUM_W'(i_in_data.sample);
                    r_count     <= r_count + 1'b1;
                    r_acc_fault <= r_acc_fault | i_in_data.read_fault;
                    r_acc_disc  <= r_acc_disc | w_in_disc;
                end else begin
                    r_sum       <= '0;
                    r_count     <= '0;
                    r_acc_fault <= 1'b0;
                    r_acc_disc  <= 1'b0;
                end
            end else if (i_uword.op == OP_AVG) begin
                r_sum       <= '0;
                r_count     <= '0;
                r_acc_fault <= 1'b0;
                r_acc_disc  <= 1'b0;
            end
            if (i_uword.op == OP_EMIT && !w_out_busy) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_uword.op)
            OP_ACCEPT: begin
                if (i_in_valid) begin
                    r_sample    <= i_in_data.sample;
                    r_smp_fault <= i_in_data.read_fault;
                    r_smp_disc  <= w_in_disc;
                end
            end
            OP_AVG: begin
                r_avg       <= w_avg_prod[AVG_K +: AVG_W];
                r_idx       <= IDX_W'(1);
                r_res_fault <= r_acc_fault;
                r_res_disc  <= r_acc_disc;
                r_res_inv   <= 1'b0;
            end
            OP_SEARCH: begin
                if (!w_hit && r_idx != IDX_W'(TBL_N - 1)) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            OP_PRODUCT: begin
                r_neg      <= w_prod[RAW_W+TMP_W+1];
                r_prod_mag <= w_prod_abs[DIV_W-1:0];
                r_den      <= w_r1 - w_r0;
                r_t0       <= w_t0;
            end
            OP_INTERP: begin
                r_temp <= (r_den == '0) ? w_t0_ext : w_interp[TEMP_W-1:0];
            end
            OP_TEMP_LAST: begin
                r_temp <= w_t1_ext;
            end
            OP_DIRECT: begin
                unique case (r_sensor_type)
                    SENSOR_SCALED: begin
                        r_temp      <= TEMP_W'(w_scaled >> SCALE_SHIFT);
                        r_res_fault <= r_smp_fault;
                        r_res_disc  <= r_smp_disc;
                        r_res_inv   <= 1'b0;
                    end
                    SENSOR_DIRECT: begin
                        r_temp      <= TEMP_W'(r_sample);
                        r_res_fault <= r_smp_fault;
                        r_res_disc  <= r_smp_disc;
                        r_res_inv   <= 1'b0;
                    end
                    default: begin
                        r_temp      <= '0;
                        r_res_fault <= 1'b0;
                        r_res_disc  <= 1'b0;
                        r_res_inv   <= 1'b1;
                    end
                endcase
            end
            OP_EMIT: begin
                if (!w_out_busy) begin
                    r_out.temperature  <= r_temp;
                    r_out.fault_seen   <= r_res_fault;
                    r_out.disconnected <= r_res_disc;
                    r_out.invalid_type <= r_res_inv;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_status.not_therm   = r_sensor_type != SENSOR_THERM;
    assign o_status.not_full    = r_count < COUNT_W'(SAMPLES_AVERAGED);
    assign o_status.search_more = !w_hit && (r_idx != IDX_W'(TBL_N - 1));
    assign o_status.miss        = !w_hit;
    assign o_status.div_more    = w_div_more;
    assign o_status.out_busy    = w_out_busy;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### src/thermistor_temperature_converter_core.sv
// Channel   Signals                                   Moves
// cfg       i_cfg_valid / o_cfg_ready, i_cfg_data     sensor type write, always ready
// in        i_in_valid / o_in_ready, i_in_data        one sample request
// out       o_out_valid / i_out_ready, o_out_data     one temperature result
//
// A thermistor sample that does not complete an average is only accumulated.
// A completing sample is averaged and the table is scanned; past the table end
// the last entry's temperature is taken, else the value is interpolated in the
// bit-serial interpolation divider. Other sensor types are converted directly.
// Synchronous active-low reset; no clearing pass. A stalled output holds the
// sequencer at its emit step until the previous result moves; the next request is taken once the new result is written.
module thermistor_temperature_converter_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  tlc_pkg::t_sensor   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tlc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tlc_pkg::t_out_item o_out_data
);
    import tlc_pkg::*;

    t_uword  w_uword;
    t_status w_status;

    tlc_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_uword    (w_uword)
    );

    tlc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uword     (w_uword),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_status    (w_status)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = w_uword.op == OP_ACCEPT;

endmodule
